FILE: rtl/core/tim_pkg.sv
// Shared types and constants for the taint interval map.
package tim_pkg;

   localparam int TableEntries = 64;
   localparam int AddrBits = 48;
   localparam int ColorBits = 16;
   localparam int SizeBits = 32;
   localparam int IdxBits = $clog2(TableEntries);
   localparam int CntBits = $clog2(TableEntries + 1);

   localparam logic [1:0] CMD_CHECK = 2'd0;
   localparam logic [1:0] CMD_TAINT = 2'd1;
   localparam logic [1:0] CMD_FREE  = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_BAD  = 2'd2;

   typedef struct packed {
      logic [AddrBits-1:0]  start;
      logic [AddrBits-1:0]  stop;
      logic [ColorBits-1:0] color;
   } entry_type;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [AddrBits-1:0]  address;
      logic [SizeBits-1:0]  size;
      logic [ColorBits-1:0] color;
   } req_type;

   typedef struct packed {
      logic [ColorBits-1:0] found_color;
      logic [1:0]           status;
   } rsp_type;

   // Classification of one stored entry against the range [lo, hi].
   typedef struct packed {
      logic left;      // some part lies below lo
      logic right;     // some part lies above hi
      logic overlap;   // touches the range
   } cls_type;

endpackage

FILE: rtl/core/tim_if.sv
// Valid/ready channel interface carrying one payload beat.
interface tim_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/tim_cmp.sv
// Shared compare unit: classifies one table entry against the active range.
module tim_cmp (
   input  tim_pkg::entry_type             entry,
   input  logic [tim_pkg::AddrBits-1:0]   lo,
   input  logic [tim_pkg::AddrBits-1:0]   hi,
   output tim_pkg::cls_type               cls
);
   // Inclusive interval tests.
   always_comb begin
      cls.left    = entry.start < lo;
      cls.right   = entry.stop > hi;
      cls.overlap = (entry.stop >= lo) && (entry.start <= hi);
   end
endmodule

FILE: rtl/core/taint_interval_map_top.sv
// Top level of the taint interval map: sequencer, table memory and result register.
//
// The block keeps a sorted table of disjoint inclusive address intervals with
// colors. Requests arrive on the req_ channel (cmd, address, size, color) and
// each produces exactly one beat on the rsp_ channel (found_color, status).
// One request is handled at a time; req_ready is low while it is in work.
// Every table entry visited takes a read slot and then a compare or a move,
// since the table memory has a registered read. A check stops at the first
// entry that overlaps the range; a taint or free scans the whole table, moves
// the entries above the range and writes the cut pieces and, for a taint, the
// new interval, unless the result would not fit. A bad size, an address wrap
// or the unused command goes straight to the result. The next request can be
// accepted in the cycle after the result is registered. A result waits in the
// output register while rsp_ready is low, and the next request is still
// accepted meanwhile; its own result then holds in the sequencer until the
// output register is free.
// Reset empties the table (the count goes to zero, no clearing pass) and
// returns the sequencer to idle.
module taint_interval_map_top (
   input logic    clock,
   input logic    reset,
   tim_if.sink    req,
   tim_if.source  rsp
);
   localparam int AB = tim_pkg::AddrBits;
   localparam int IB = tim_pkg::IdxBits;
   localparam int CB = tim_pkg::CntBits;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SCAN  = 4'd1;
   localparam logic [3:0] ST_SCANW = 4'd2;
   localparam logic [3:0] ST_DEC   = 4'd3;
   localparam logic [3:0] ST_MOVR  = 4'd4;
   localparam logic [3:0] ST_MOVW  = 4'd5;
   localparam logic [3:0] ST_PUT   = 4'd6;
   localparam logic [3:0] ST_DONE  = 4'd7;

   // Table memory.
   tim_pkg::entry_type mem [tim_pkg::TableEntries];
   tim_pkg::entry_type rd_ff;
   logic               we;
   logic [IB-1:0]      waddr, raddr;
   tim_pkg::entry_type wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   logic [3:0]               state_ff, state_in;
   logic [CB-1:0]            count_ff, count_in;
   logic [CB-1:0]            idx_ff, idx_in;
   logic [CB-1:0]            nl_ff, nl_in;        // entries entirely/partly below lo
   logic [CB-1:0]            nr_ff, nr_in;        // entries partly/entirely above hi
   logic [CB-1:0]            rfirst_ff, rfirst_in; // index of first entry above hi
   logic                     rset_ff, rset_in;
   logic                     lcut_ff, lcut_in;    // last left entry needs cutting
   logic                     rcut_ff, rcut_in;    // first right entry needs cutting
   tim_pkg::entry_type       lent_ff, lent_in;
   tim_pkg::entry_type       rent_ff, rent_in;
   logic [1:0]               put_ff, put_in;
   logic [1:0]               cmd_ff, cmd_in;
   logic [AB-1:0]            lo_ff, lo_in, hi_ff, hi_in;
   logic [tim_pkg::ColorBits-1:0] col_ff, col_in;
   tim_pkg::rsp_type         res_ff, res_in;      // result being built
   tim_pkg::rsp_type         out_ff, out_in;
   logic                     ov_ff, ov_in;
   tim_pkg::cls_type         cls;
   logic [CB:0]              total;
   logic [AB:0]              last_addr;
   logic                     grow;

   tim_cmp u_cmp (.entry(rd_ff), .lo(lo_ff), .hi(hi_ff), .cls(cls));

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = ov_ff;
   assign rsp.payload = out_ff;

   assign last_addr = {1'b0, req.payload.address}
                    + AB'(req.payload.size) + {(AB+1){1'b1}};
   assign total = (CB+1)'(nl_ff) + (CB+1)'(nr_ff)
                + (CB+1)'(cmd_ff == tim_pkg::CMD_TAINT);
   assign grow = total > (CB+1)'(count_ff);

   // Sequencer.
   always_comb begin
      state_in = state_ff;  count_in = count_ff;  idx_in = idx_ff;
      nl_in = nl_ff;  nr_in = nr_ff;  rfirst_in = rfirst_ff;  rset_in = rset_ff;
      lcut_in = lcut_ff;  rcut_in = rcut_ff;  lent_in = lent_ff;  rent_in = rent_ff;
      put_in = put_ff;  cmd_in = cmd_ff;  lo_in = lo_ff;  hi_in = hi_ff;
      col_in = col_ff;  res_in = res_ff;  out_in = out_ff;  ov_in = ov_ff;
      we = 1'b0;  waddr = '0;  wdata = rd_ff;  raddr = idx_ff[IB-1:0];
      if (ov_ff && rsp.ready) begin
         ov_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in = req.payload.cmd;
               lo_in = req.payload.address;
               hi_in = last_addr[AB-1:0];
               col_in = req.payload.color;
               idx_in = '0;  nl_in = '0;  nr_in = '0;  rset_in = 1'b0;
               lcut_in = 1'b0;  rcut_in = 1'b0;
               rfirst_in = count_ff;
               res_in = '0;
               raddr = '0;
               if (req.payload.cmd == tim_pkg::CMD_NONE) begin
                  state_in = ST_DONE;
               end else if (req.payload.size == '0 || last_addr[AB]) begin
                  res_in.status = tim_pkg::STATUS_BAD;
                  state_in = ST_DONE;
               end else begin
                  state_in = (count_ff == '0) ? ST_DEC : ST_SCANW;
               end
            end
         end
         ST_SCANW: begin
            // Memory read latency slot.
            raddr = idx_ff[IB-1:0];
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // Each entry passes through the shared compare unit after its read slot.
            if (cmd_ff == tim_pkg::CMD_CHECK && cls.overlap) begin
               res_in.found_color = rd_ff.color;
               state_in = ST_DONE;
            end else begin
               if (cls.left) begin
                  nl_in = nl_ff + CB'(1);
                  lent_in = rd_ff;
                  lcut_in = rd_ff.stop >= lo_ff;
               end
               if (cls.right) begin
                  nr_in = nr_ff + CB'(1);
                  if (!rset_ff) begin
                     rset_in = 1'b1;
                     rfirst_in = idx_ff;
                     rent_in = rd_ff;
                     rcut_in = rd_ff.start <= hi_ff;
                  end
               end
               idx_in = idx_ff + CB'(1);
               raddr = idx_in[IB-1:0];
               if (idx_in == count_ff) begin
                  state_in = (cmd_ff == tim_pkg::CMD_CHECK) ? ST_DONE : ST_DEC;
               end else begin
                  state_in = ST_SCANW;
               end
            end
         end
         ST_DEC: begin
            if (cmd_ff == tim_pkg::CMD_CHECK) begin
               state_in = ST_DONE;
            end else if (total > (CB+1)'(tim_pkg::TableEntries)) begin
               res_in.status = tim_pkg::STATUS_FULL;
               state_in = ST_DONE;
            end else begin
               put_in = 2'd0;
               if (nr_ff == '0) begin
                  state_in = ST_PUT;
               end else begin
                  // Grow: move from the top entry down; shrink: from the first.
                  idx_in = grow ? (count_ff - CB'(1)) : rfirst_ff;
                  raddr = idx_in[IB-1:0];
                  state_in = ST_MOVR;
               end
            end
         end
         ST_MOVR: begin
            state_in = ST_MOVW;
         end
         ST_MOVW: begin
            // Entry idx goes to idx - rfirst + (total - nr).
            we = 1'b1;
            waddr = IB'(idx_ff - rfirst_ff + CB'(total) - nr_ff);
            wdata = rd_ff;
            if (grow ? (idx_ff == rfirst_ff) : (idx_ff == count_ff - CB'(1))) begin
               state_in = ST_PUT;
            end else begin
               idx_in = grow ? (idx_ff - CB'(1)) : (idx_ff + CB'(1));
               raddr = idx_in[IB-1:0];
               state_in = ST_MOVR;
            end
         end
         ST_PUT: begin
            // Cut left piece, new interval, cut right piece.
            unique case (put_ff)
               2'd0: begin
                  we = lcut_ff;
                  waddr = IB'(nl_ff - CB'(1));
                  wdata = lent_ff;
                  wdata.stop = lo_ff - AB'(1);
                  put_in = 2'd1;
               end
               2'd1: begin
                  we = (cmd_ff == tim_pkg::CMD_TAINT);
                  waddr = IB'(nl_ff);
                  wdata.start = lo_ff;  wdata.stop = hi_ff;  wdata.color = col_ff;
                  put_in = 2'd2;
               end
               default: begin
                  we = rcut_ff && (nr_ff != '0);
                  waddr = IB'(CB'(total) - nr_ff);
                  wdata = rent_ff;
                  wdata.start = hi_ff + AB'(1);
                  count_in = CB'(total);
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            // Hand the result over once the output register is free.
            if (!ov_ff || rsp.ready) begin
               out_in = res_ff;
               ov_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ov_ff <= ov_in;
      end
      idx_ff <= idx_in;  nl_ff <= nl_in;  nr_ff <= nr_in;  rfirst_ff <= rfirst_in;
      rset_ff <= rset_in;  lcut_ff <= lcut_in;  rcut_ff <= rcut_in;
      lent_ff <= lent_in;  rent_ff <= rent_in;  put_ff <= put_in;  cmd_ff <= cmd_in;
      lo_ff <= lo_in;  hi_ff <= hi_in;  col_ff <= col_in;  res_ff <= res_in;
      out_ff <= out_in;
   end

   // The table never holds more than its capacity.
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(tim_pkg::TableEntries)) else $error("count overflow");
   // The count changes only at the end of a taint or free.
   a_cnt_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_PUT) |=> $stable(count_ff)) else $error("count moved");
   // A stalled result beat stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.payload)))
      else $error("result beat changed while stalled");
endmodule

FILE: tb/taint_interval_map_top_test.sv
// Self-checking test of the taint interval map: directed and random commands against a predictor.
module taint_interval_map_top_test;

   logic clock;
   logic reset;
   bit   failed;
   int unsigned cycle_count;

   tim_if #(.payload_type(tim_pkg::req_type)) req_ch (.clock(clock));
   tim_if #(.payload_type(tim_pkg::rsp_type)) rsp_ch (.clock(clock));

   taint_interval_map_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // Shadow copy of the interval table.
   logic [tim_pkg::AddrBits-1:0]  shadow_start[$];
   logic [tim_pkg::AddrBits-1:0]  shadow_stop[$];
   logic [tim_pkg::ColorBits-1:0] shadow_color[$];
   tim_pkg::rsp_type              pending_rsp[$];
   bit                            rsp_idle_enable;

   localparam logic [tim_pkg::AddrBits-1:0] AddrMax = '1;

   // Predict the response to one request and update the shadow table.
   function automatic tim_pkg::rsp_type predict_request(tim_pkg::req_type r);
      tim_pkg::rsp_type              res;
      logic [tim_pkg::AddrBits-1:0]  lo;
      logic [tim_pkg::AddrBits-1:0]  hi;
      logic [tim_pkg::AddrBits-1:0]  ns[$];
      logic [tim_pkg::AddrBits-1:0]  ne[$];
      logic [tim_pkg::ColorBits-1:0] nc[$];
      logic [63:0]                   span;
      res = '0;
      if (r.cmd == tim_pkg::CMD_NONE) return res;
      span = {32'd0, r.size} - 64'd1;
      if (r.size == 0 || span > {16'd0, AddrMax - r.address}) begin
         res.status = tim_pkg::STATUS_BAD;
         return res;
      end
      lo = r.address;
      hi = r.address + span[tim_pkg::AddrBits-1:0];
      if (r.cmd == tim_pkg::CMD_CHECK) begin
         foreach (shadow_start[i]) begin
            if (shadow_stop[i] >= lo && shadow_start[i] <= hi) begin
               res.found_color = shadow_color[i];
               break;
            end
         end
         return res;
      end
      // Pieces below the range, then the new interval, then pieces above.
      foreach (shadow_start[i]) begin
         if (shadow_start[i] < lo) begin
            ns.push_back(shadow_start[i]);
            ne.push_back(shadow_stop[i] < lo ? shadow_stop[i] : lo - 1);
            nc.push_back(shadow_color[i]);
         end
      end
      if (r.cmd == tim_pkg::CMD_TAINT) begin
         ns.push_back(lo);
         ne.push_back(hi);
         nc.push_back(r.color);
      end
      foreach (shadow_start[i]) begin
         if (shadow_stop[i] > hi) begin
            ns.push_back(shadow_start[i] > hi ? shadow_start[i] : hi + 1);
            ne.push_back(shadow_stop[i]);
            nc.push_back(shadow_color[i]);
         end
      end
      if (ns.size() > tim_pkg::TableEntries) begin
         res.status = tim_pkg::STATUS_FULL;
         return res;
      end
      shadow_start = ns;
      shadow_stop = ne;
      shadow_color = nc;
      return res;
   endfunction

   // Clock and cycle limit.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("taint_interval_map_top test failed");
         $finish;
      end
   end

   // Response side: random stalls and comparison against the oldest expectation.
   int unsigned rsp_wait;
   always @(posedge clock) begin
      tim_pkg::rsp_type exp_rsp;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
               $error("response beat with no expectation");
               failed = 1'b1;
            end else begin
               exp_rsp = pending_rsp.pop_front();
               if (rsp_ch.payload.found_color !== exp_rsp.found_color) begin
                  $error("found_color expected %0h actual %0h",
                         exp_rsp.found_color, rsp_ch.payload.found_color);
                  failed = 1'b1;
               end
               if (rsp_ch.payload.status !== exp_rsp.status) begin
                  $error("status expected %0d actual %0d",
                         exp_rsp.status, rsp_ch.payload.status);
                  failed = 1'b1;
               end
            end
         end
         if (rsp_wait != 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait <= rsp_wait - 1;
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_idle_enable && $urandom_range(0, 1)) begin
               rsp_ch.ready <= 1'b0;
               rsp_wait <= $urandom_range(0, 9);
            end else begin
               rsp_ch.ready <= 1'b1;
            end
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   bit req_idle_enable;

   // Send one request beat, with an optional idle gap before it.
   task automatic send_request(logic [1:0] cmd, logic [tim_pkg::AddrBits-1:0] address,
                               logic [tim_pkg::SizeBits-1:0] size,
                               logic [tim_pkg::ColorBits-1:0] color);
      tim_pkg::req_type r;
      int               gap;
      r.cmd = cmd;
      r.address = address;
      r.size = size;
      r.color = color;
      gap = req_idle_enable ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_rsp.push_back(predict_request(r));
   endtask

   // Random address, mostly inside a small window so that intervals collide.
   function automatic logic [tim_pkg::AddrBits-1:0] pick_address();
      case ($urandom_range(0, 9))
         0:       return 48'({$urandom, $urandom});
         1:       return AddrMax - $urandom_range(0, 300);
         default: return 48'h1000 + $urandom_range(0, 600);
      endcase
   endfunction

   function automatic logic [tim_pkg::SizeBits-1:0] pick_size();
      case ($urandom_range(0, 11))
         0:       return 32'd0;
         1:       return $urandom;
         default: return $urandom_range(1, 40);
      endcase
   endfunction

   task automatic test_directed();
      send_request(tim_pkg::CMD_CHECK, 48'h0, 32'd1, 16'h0);
      send_request(tim_pkg::CMD_TAINT, 48'h0, 32'd16, 16'hffff);
      send_request(tim_pkg::CMD_TAINT, AddrMax, 32'd1, 16'h0001);
      send_request(tim_pkg::CMD_TAINT, AddrMax - 1, 32'd3, 16'h1234);
      send_request(tim_pkg::CMD_CHECK, 48'h0, 32'hffff_ffff, 16'h0);
      send_request(tim_pkg::CMD_TAINT, 48'h4, 32'd4, 16'h00aa);
      send_request(tim_pkg::CMD_CHECK, 48'h6, 32'd1, 16'hffff);
      send_request(tim_pkg::CMD_FREE, 48'h2, 32'd1, 16'h0);
      send_request(tim_pkg::CMD_CHECK, 48'h2, 32'd1, 16'h0);
      send_request(tim_pkg::CMD_CHECK, 48'h0, 32'd2, 16'h0);
      send_request(tim_pkg::CMD_TAINT, 48'h10, 32'd0, 16'h5555);
      send_request(tim_pkg::CMD_FREE, 48'h10, 32'd0, 16'h0);
      send_request(tim_pkg::CMD_CHECK, 48'h10, 32'd0, 16'h0);
      send_request(tim_pkg::CMD_NONE, 48'h10, 32'd5, 16'h7777);
      send_request(tim_pkg::CMD_FREE, 48'h0, 32'hffff_ffff, 16'h0);
      send_request(tim_pkg::CMD_CHECK, AddrMax, 32'd1, 16'h0);
      send_request(tim_pkg::CMD_CHECK, 48'h20, 32'd1, 16'h0);
   endtask

   // Fill the table, then taint so that it would overflow; frees trim and then empty it.
   task automatic test_table_full();
      for (int i = 0; i < tim_pkg::TableEntries; i++)
         send_request(tim_pkg::CMD_TAINT, 48'h8000 + 48'(i * 4), 32'd2, 16'(i + 1));
      send_request(tim_pkg::CMD_TAINT, 48'h9000, 32'd1, 16'hbeef);
      send_request(tim_pkg::CMD_FREE, 48'h8000, 32'd1, 16'h0);
      send_request(tim_pkg::CMD_TAINT, 48'h8004, 32'd1, 16'h0bad);
      send_request(tim_pkg::CMD_CHECK, 48'h8004, 32'd2, 16'h0);
      send_request(tim_pkg::CMD_FREE, 48'h0, 32'hffff_ffff, 16'h0);
      send_request(tim_pkg::CMD_FREE, 48'hffff_0000_0000, 32'hffff_ffff, 16'h0);
   endtask

   task automatic test_random();
      int unsigned kind;
      for (int n = 0; n < 1620; n++) begin
         req_idle_enable = (n % 400) >= 100;
         rsp_idle_enable = (n % 500) < 350;
         kind = $urandom_range(0, 19);
         if (kind == 0)
            send_request(tim_pkg::CMD_FREE, 48'h0, 32'hffff_ffff, 16'($urandom));
         else if (kind == 1)
            send_request(tim_pkg::CMD_NONE, 48'({$urandom, $urandom}), $urandom,
                         16'($urandom));
         else
            send_request(2'($urandom_range(0, 2)), pick_address(), pick_size(),
                         16'($urandom));
      end
   endtask

   initial begin
      failed = 1'b0;
      cycle_count = 0;
      rsp_idle_enable = 1'b1;
      req_idle_enable = 1'b1;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_full();
      test_random();
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (!failed)
         $display("taint_interval_map_top test passed");
      else
         $display("taint_interval_map_top test failed");
      $finish;
   end
endmodule

FILE: sim.f
rtl/core/tim_pkg.sv
rtl/core/tim_if.sv
rtl/core/tim_cmp.sv
rtl/core/taint_interval_map_top.sv
tb/taint_interval_map_top_test.sv
